@@ sv/ttm_pkg.sv @@
`timescale 1ns / 1ps
// shared types, widths and angle constants for the tilt / heading pipeline
// no dependencies

package ttm_pkg;

	localparam int OP_W        = 36;  // cordic operand width, raw sample scaled by 2^16 plus growth
	localparam int ANG_W       = 35;  // angle width, 1/65536 hundredth of a degree
	localparam int ITERS       = 25;
	localparam int SQ_W        = 32;
	localparam int SQRT_STAGES = 32;
	localparam int CORDIC_LAT  = ITERS + 1;
	localparam int SAMPLE_W    = 16;
	localparam int FRAC        = 16;

	typedef logic signed [OP_W-1:0]  op_t;
	typedef logic signed [ANG_W-1:0] ang_t;

	localparam ang_t ANG_90  = 35'sd589824000;
	localparam ang_t ANG_180 = 35'sd1179648000;
	localparam ang_t ANG_360 = 35'sd2359296000;

	function automatic ang_t atan_entry(input int i);
		ang_t r;
		case (i)
			0:  r = 35'sd294912000;
			1:  r = 35'sd174096719;
			2:  r = 35'sd91987925;
			3:  r = 35'sd46694507;
			4:  r = 35'sd23437865;
			5:  r = 35'sd11730358;
			6:  r = 35'sd5866610;
			7:  r = 35'sd2933484;
			8:  r = 35'sd1466765;
			9:  r = 35'sd733385;
			10: r = 35'sd366693;
			11: r = 35'sd183346;
			12: r = 35'sd91673;
			13: r = 35'sd45837;
			14: r = 35'sd22899;
			15: r = 35'sd11450;
			16: r = 35'sd5725;
			17: r = 35'sd2862;
			18: r = 35'sd1431;
			19: r = 35'sd716;
			20: r = 35'sd358;
			21: r = 35'sd179;
			22: r = 35'sd89;
			23: r = 35'sd45;
			24: r = 35'sd22;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ sv/ttm_delay.sv @@
`timescale 1ns / 1ps
// enabled shift line that keeps side data aligned with the pipeline
// no package dependency

module ttm_delay #(
	parameter int W = 16,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] din,
	output logic [W-1:0] dout
);

	logic [W-1:0] tap_s [0:D-1];

	always_ff @(posedge clk) begin
		if (en) begin
			tap_s[0] <= din;
		end
	end

	for (genvar k = 1; k < D; k++) begin : g_tap
		always_ff @(posedge clk) begin
			if (en) begin
				tap_s[k] <= tap_s[k-1];
			end
		end
	end

	assign dout = tap_s[D-1];

endmodule

@@ sv/ttm_isqrt.sv @@
`timescale 1ns / 1ps
// pipelined floor(sqrt(sq * 2^32)), one result bit per stage
// depends on ttm_pkg

module ttm_isqrt (
	input  logic                      clk,
	input  logic                      en,
	input  logic [ttm_pkg::SQ_W-1:0]  sq,
	output logic [ttm_pkg::SQ_W-1:0]  root
);

	localparam int N    = ttm_pkg::SQRT_STAGES;
	localparam int HALF = ttm_pkg::SQ_W / 2;

	logic [ttm_pkg::SQ_W+1:0] rem_s  [0:N-1];
	logic [ttm_pkg::SQ_W-1:0] root_s [0:N];
	logic [ttm_pkg::SQ_W-1:0] sq_s   [0:HALF-1];

	assign rem_s[0]  = '0;
	assign root_s[0] = '0;
	assign sq_s[0]   = sq;

	for (genvar k = 0; k < N; k++) begin : g_stage
		logic [1:0]               pair;
		logic [ttm_pkg::SQ_W+1:0] cur;
		logic [ttm_pkg::SQ_W+1:0] trial;
		logic                     fits;

		// the low half of the radicand is all zeros
		if (k < HALF) begin : g_pair
			assign pair = sq_s[k][ttm_pkg::SQ_W-1-2*k -: 2];
		end else begin : g_zero
			assign pair = 2'b00;
		end

		assign cur   = {rem_s[k][ttm_pkg::SQ_W-1:0], pair};
		assign trial = {root_s[k], 2'b01};
		assign fits  = (cur >= trial);

		always_ff @(posedge clk) begin
			if (en) begin
				root_s[k+1] <= {root_s[k][ttm_pkg::SQ_W-2:0], fits};
			end
		end

		if (k < N - 1) begin : g_rem
			always_ff @(posedge clk) begin
				if (en) begin
					rem_s[k+1] <= fits ? (cur - trial) : cur;
				end
			end
		end

		if (k + 1 < HALF) begin : g_sq
			always_ff @(posedge clk) begin
				if (en) begin
					sq_s[k+1] <= sq_s[k];
				end
			end
		end
	end

	assign root = root_s[N];

endmodule

@@ sv/ttm_cordic.sv @@
`timescale 1ns / 1ps
// pipelined vectoring cordic atan2(y, x), one iteration per stage
// depends on ttm_pkg

module ttm_cordic (
	input  logic          clk,
	input  logic          en,
	input  ttm_pkg::op_t  y_in,
	input  ttm_pkg::op_t  x_in,
	output ttm_pkg::ang_t ang
);

	localparam int N = ttm_pkg::ITERS;

	ttm_pkg::op_t  x_s  [0:N];
	ttm_pkg::op_t  y_s  [0:N];
	ttm_pkg::ang_t z_s  [0:N];
	logic          sp_s [0:N];

	ttm_pkg::op_t  xf, yf;
	ttm_pkg::ang_t z0;
	logic          spec;

	// axis cases are exact, left half-plane is folded by 180 degrees
	always_comb begin
		spec = 1'b0;
		z0   = '0;
		xf   = x_in;
		yf   = y_in;
		if (x_in == '0 && y_in == '0) begin
			spec = 1'b1;
		end else if (x_in == '0) begin
			spec = 1'b1;
			z0   = y_in[ttm_pkg::OP_W-1] ? -ttm_pkg::ANG_90 : ttm_pkg::ANG_90;
		end else if (y_in == '0) begin
			spec = 1'b1;
			z0   = x_in[ttm_pkg::OP_W-1] ? ttm_pkg::ANG_180 : '0;
		end else if (x_in[ttm_pkg::OP_W-1]) begin
			z0 = y_in[ttm_pkg::OP_W-1] ? -ttm_pkg::ANG_180 : ttm_pkg::ANG_180;
			xf = -x_in;
			yf = -y_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]  <= xf;
			y_s[0]  <= yf;
			z_s[0]  <= z0;
			sp_s[0] <= spec;
		end
	end

	for (genvar i = 0; i < N; i++) begin : g_iter
		localparam ttm_pkg::ang_t A = ttm_pkg::atan_entry(i);
		ttm_pkg::op_t xs, ys;
		assign xs = x_s[i] >>> i;
		assign ys = y_s[i] >>> i;

		always_ff @(posedge clk) begin
			if (en) begin
				sp_s[i+1] <= sp_s[i];
				if (!y_s[i][ttm_pkg::OP_W-1]) begin
					x_s[i+1] <= x_s[i] + ys;
					y_s[i+1] <= y_s[i] - xs;
					z_s[i+1] <= sp_s[i] ? z_s[i] : z_s[i] + A;
				end else begin
					x_s[i+1] <= x_s[i] - ys;
					y_s[i+1] <= y_s[i] + xs;
					z_s[i+1] <= sp_s[i] ? z_s[i] : z_s[i] - A;
				end
			end
		end
	end

	assign ang = z_s[N];

endmodule

@@ sv/tilt_heading_from_accel_mag_top.sv @@
`timescale 1ns / 1ps
// top level: roll, pitch and declination-corrected heading from accel and mag samples
// depends on ttm_pkg, ttm_isqrt, ttm_cordic, ttm_delay

// Accepts one sample set per clock while not stalled and returns one result per sample,
// in order. The depth is set by the 32-stage square root (one root bit per stage) feeding
// a 26-stage CORDIC for pitch; roll and heading run in their own CORDIC pipelines and are
// delayed to match. Angles are hundredths of a degree, rounded to nearest. A stall on a
// valid output freezes the whole pipeline and is passed back to the input in the same
// cycle. Declination is a plain register that the user must write only while the pipeline
// holds no transaction; the block does not enforce this. cfg_ready is always high.

module tilt_heading_from_accel_mag_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [15:0] accel_x,
	input  logic signed [15:0] accel_y,
	input  logic signed [15:0] accel_z,
	input  logic signed [15:0] mag_x,
	input  logic signed [15:0] mag_y,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [15:0] roll,
	output logic signed [14:0] pitch,
	output logic signed [16:0] heading,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic signed [15:0] cfg_data
);

	localparam int SW  = ttm_pkg::SAMPLE_W;
	localparam int OPX = ttm_pkg::OP_W - SW - ttm_pkg::FRAC;
	localparam int AGX = ttm_pkg::ANG_W - SW - ttm_pkg::FRAC;
	localparam int VL  = 1 + ttm_pkg::SQRT_STAGES + ttm_pkg::CORDIC_LAT + 2;

	logic en;
	logic v_s [0:VL-1];
	logic out_valid_q;
	logic signed [15:0] decl_q;

	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			decl_q <= '0;
		end else if (cfg_valid) begin
			decl_q <= cfg_data;
		end
	end

	// valid bits march in lockstep with the payload
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < VL; k++) v_s[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			v_s[0] <= in_valid;
			for (int k = 1; k < VL; k++) v_s[k] <= v_s[k-1];
			out_valid_q <= v_s[VL-1];
		end
	end

	// stage 1: squares and cordic operands
	logic signed [31:0] ayy, azz;
	ttm_pkg::op_t roll_y, roll_x, yaw_y, yaw_x;
	assign ayy = accel_y * accel_y;
	assign azz = accel_z * accel_z;
	assign roll_y = {{OPX{accel_y[SW-1]}}, accel_y, {ttm_pkg::FRAC{1'b0}}};
	assign roll_x = {{OPX{accel_z[SW-1]}}, accel_z, {ttm_pkg::FRAC{1'b0}}};
	assign yaw_y  = (mag_y == '0) ? '0 : {{OPX{mag_x[SW-1]}}, mag_x, {ttm_pkg::FRAC{1'b0}}};
	// zero mag_y: a unit x of the right sign gives 0 or 180 degrees
	assign yaw_x  = (mag_y == '0) ? (mag_x[SW-1] ? -ttm_pkg::op_t'(1) : ttm_pkg::op_t'(1))
		: {{OPX{mag_y[SW-1]}}, mag_y, {ttm_pkg::FRAC{1'b0}}};

	logic [ttm_pkg::SQ_W-1:0] sq_s1;
	logic signed [15:0]       ax_s1;
	ttm_pkg::op_t             roll_y_s1, roll_x_s1, yaw_y_s1, yaw_x_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s1     <= ayy + azz;
			ax_s1     <= accel_x;
			roll_y_s1 <= roll_y;
			roll_x_s1 <= roll_x;
			yaw_y_s1  <= yaw_y;
			yaw_x_s1  <= yaw_x;
		end
	end

	// pitch path: root, then cordic
	logic [ttm_pkg::SQ_W-1:0] den;
	logic [15:0]              ax_d;
	ttm_pkg::op_t             pitch_y, pitch_x;
	ttm_pkg::ang_t            pitch_c, roll_c, yaw_c, roll_d, yaw_d;

	ttm_isqrt u_isqrt (.clk(clk), .en(en), .sq(sq_s1), .root(den));

	ttm_delay #(.W(SW), .D(ttm_pkg::SQRT_STAGES)) u_ax_dly (
		.clk(clk), .en(en), .din(ax_s1), .dout(ax_d)
	);

	assign pitch_y = -{{OPX{ax_d[SW-1]}}, ax_d, {ttm_pkg::FRAC{1'b0}}};
	assign pitch_x = {{(ttm_pkg::OP_W-ttm_pkg::SQ_W){1'b0}}, den};

	ttm_cordic u_pitch (.clk(clk), .en(en), .y_in(pitch_y), .x_in(pitch_x), .ang(pitch_c));
	ttm_cordic u_roll  (.clk(clk), .en(en), .y_in(roll_y_s1), .x_in(roll_x_s1), .ang(roll_c));
	ttm_cordic u_yaw   (.clk(clk), .en(en), .y_in(yaw_y_s1), .x_in(yaw_x_s1), .ang(yaw_c));

	ttm_delay #(.W(ttm_pkg::ANG_W), .D(ttm_pkg::SQRT_STAGES)) u_roll_dly (
		.clk(clk), .en(en), .din(roll_c), .dout(roll_d)
	);
	ttm_delay #(.W(ttm_pkg::ANG_W), .D(ttm_pkg::SQRT_STAGES)) u_yaw_dly (
		.clk(clk), .en(en), .din(yaw_c), .dout(yaw_d)
	);

	// declination, wrap, round
	ttm_pkg::ang_t roll_s2, pitch_s2, yaw_s2, roll_s3, pitch_s3, yaw_s3, yaw_w;
	ttm_pkg::ang_t roll_r, pitch_r, yaw_r;

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s2  <= roll_d;
			pitch_s2 <= pitch_c;
			yaw_s2   <= yaw_d - {{AGX{decl_q[15]}}, decl_q, {ttm_pkg::FRAC{1'b0}}};
		end
	end

	always_comb begin
		yaw_w = yaw_s2;
		if (yaw_s2 > ttm_pkg::ANG_180) begin
			yaw_w = yaw_s2 - ttm_pkg::ANG_360;
		end else if (yaw_s2 < -ttm_pkg::ANG_180) begin
			yaw_w = yaw_s2 + ttm_pkg::ANG_360;
		end else if (yaw_s2[ttm_pkg::ANG_W-1]) begin
			yaw_w = yaw_s2 + ttm_pkg::ANG_360;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			roll_s3  <= roll_s2;
			pitch_s3 <= pitch_s2;
			yaw_s3   <= yaw_w;
		end
	end

	localparam ttm_pkg::ang_t HALF_LSB = ttm_pkg::ang_t'(1) <<< (ttm_pkg::FRAC - 1);
	assign roll_r  = roll_s3 + HALF_LSB;
	assign pitch_r = pitch_s3 + HALF_LSB;
	assign yaw_r   = yaw_s3 + HALF_LSB;

	always_ff @(posedge clk) begin
		if (en) begin
			roll    <= roll_r[ttm_pkg::FRAC +: 16];
			pitch   <= pitch_r[ttm_pkg::FRAC +: 15];
			heading <= yaw_r[ttm_pkg::FRAC +: 17];
		end
	end

`ifndef SYNTHESIS
	// pitch has a nonnegative denominator, so it never leaves the right half-plane
	a_pitch_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pitch >= -15'sd9000 && pitch <= 15'sd9000))
		else $error("pitch out of range");

	a_roll_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (roll >= -16'sd18000 && roll <= 16'sd18000))
		else $error("roll out of range");

	// a held result must also hold the input side
	a_stall_back: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |-> in_stall)
		else $error("input taken while output held");
`endif

endmodule

@@ sim/tb_tilt_heading_from_accel_mag_top.sv @@
`timescale 1ns / 1ps
// testbench for tilt_heading_from_accel_mag_top: random and corner sensor samples with
// an in-order expected-angle queue; depends on ttm_pkg and the block's rtl

class angle_scoreboard;
	typedef struct {
		logic signed [15:0] roll;
		logic signed [14:0] pitch;
		logic signed [16:0] heading;
	} angles_t;

	angles_t pending[$];
	longint  decl;
	int      errors;

	function new();
		decl = 0;
		errors = 0;
	endfunction

	static function longint floor_shr(longint v, int s);
		if (v >= 0) return v >>> s;
		return -(((-v) - 1) >>> s) - 1;
	endfunction

	static function longint int_sqrt(longint unsigned n);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > n) b >>= 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return longint'(r);
	endfunction

	static function longint cordic_atan2(longint y, longint x);
		longint z, xs, ys;
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x == 0) return (y > 0) ? longint'(ttm_pkg::ANG_90) : -longint'(ttm_pkg::ANG_90);
		if (y == 0) return (x > 0) ? 0 : longint'(ttm_pkg::ANG_180);
		if (x < 0) begin
			z = (y > 0) ? longint'(ttm_pkg::ANG_180) : -longint'(ttm_pkg::ANG_180);
			x = -x;
			y = -y;
		end
		for (int i = 0; i < ttm_pkg::ITERS; i++) begin
			xs = floor_shr(x, i);
			ys = floor_shr(y, i);
			if (y >= 0) begin
				x += ys;
				y -= xs;
				z += atan_step(i);
			end else begin
				x -= ys;
				y += xs;
				z -= atan_step(i);
			end
		end
		return z;
	endfunction

	static function longint atan_step(int i);
		longint t[25] = '{294912000, 174096719, 91987925, 46694507, 23437865,
			11730358, 5866610, 2933484, 1466765, 733385, 366693, 183346, 91673,
			45837, 22899, 11450, 5725, 2862, 1431, 716, 358, 179, 89, 45, 22};
		return t[i];
	endfunction

	static function longint to_centideg(longint z);
		return floor_shr(z + 32768, 16);
	endfunction

	function void note_sample(logic signed [15:0] ax, ay, az, mx, my);
		longint sax, say, saz, smx, smy, den, yaw, r, p, h;
		longint unsigned sq;
		angles_t e;
		sax = ax; say = ay; saz = az; smx = mx; smy = my;
		sq = longint'(say * say + saz * saz);
		den = int_sqrt(sq << 32);
		r = cordic_atan2(say * 65536, saz * 65536);
		p = cordic_atan2(-sax * 65536, den);
		if (smy == 0) yaw = (smx < 0) ? longint'(ttm_pkg::ANG_180) : 0;
		else yaw = cordic_atan2(smx * 65536, smy * 65536);
		yaw -= decl * 65536;
		if (yaw > longint'(ttm_pkg::ANG_180)) yaw -= longint'(ttm_pkg::ANG_360);
		else if (yaw < -longint'(ttm_pkg::ANG_180)) yaw += longint'(ttm_pkg::ANG_360);
		else if (yaw < 0) yaw += longint'(ttm_pkg::ANG_360);
		h = to_centideg(yaw);
		r = to_centideg(r);
		p = to_centideg(p);
		e.roll = r[15:0];
		e.pitch = p[14:0];
		e.heading = h[16:0];
		pending.push_back(e);
	endfunction

	function void check_result(logic signed [15:0] r, logic signed [14:0] p,
			logic signed [16:0] h);
		angles_t e;
		if (pending.size() == 0) begin
			$error("result with no expected transaction");
			errors++;
			return;
		end
		e = pending.pop_front();
		if (r !== e.roll) begin
			$error("roll expected %0d actual %0d", e.roll, r);
			errors++;
		end
		if (p !== e.pitch) begin
			$error("pitch expected %0d actual %0d", e.pitch, p);
			errors++;
		end
		if (h !== e.heading) begin
			$error("heading expected %0d actual %0d", e.heading, h);
			errors++;
		end
	endfunction
endclass

module tb_tilt_heading_from_accel_mag_top;
	localparam int WATCHDOG = 20000;
	localparam int DRAIN = 200;

	logic               clk = 0;
	logic               arst_n = 0;
	logic               in_valid = 0;
	logic               in_stall;
	logic signed [15:0] accel_x = 0, accel_y = 0, accel_z = 0, mag_x = 0, mag_y = 0;
	logic               out_valid;
	logic               out_stall = 0;
	logic signed [15:0] roll;
	logic signed [14:0] pitch;
	logic signed [16:0] heading;
	logic               cfg_valid = 0;
	logic               cfg_ready;
	logic signed [15:0] cfg_data = 0;

	angle_scoreboard sb = new();
	int  idle_cycles = 0;
	bit  stall_random = 0;
	int  stall_mode = 0;

	tilt_heading_from_accel_mag_top DUT (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// receiver stall pattern: off, random, or long bursts
	always @(posedge clk) begin
		if (!stall_random) out_stall <= 0;
		else case (stall_mode)
			0: out_stall <= 0;
			1: out_stall <= ($urandom_range(0, 3) == 0);
			default: out_stall <= ($urandom_range(0, 15) < 12);
		endcase
		if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) sb.check_result(roll, pitch, heading);
		if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic logic [15:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return 16'sh8000;
			1: return 16'sh7fff;
			2: return 16'd0;
			3: return 16'($urandom_range(0, 8) - 4);
			default: return 16'($urandom);
		endcase
	endfunction

	// drive one transaction and hold it until accepted
	task automatic send_sample(logic [15:0] ax, ay, az, mx, my);
		in_valid <= 1;
		accel_x <= ax; accel_y <= ay; accel_z <= az; mag_x <= mx; mag_y <= my;
		do @(posedge clk); while (in_stall);
		sb.note_sample(ax, ay, az, mx, my);
	endtask

	task automatic drop_valid();
		in_valid <= 0;
		@(posedge clk);
	endtask

	task automatic write_declination(logic signed [15:0] d);
		cfg_valid <= 1;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 0;
		sb.decl = d;
	endtask

	task automatic drain();
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		int burst;
		while (n > 0) begin
			burst = $urandom_range(1, 40);
			for (int i = 0; i < burst && n > 0; i++, n--)
				send_sample(rand_sample(), rand_sample(), rand_sample(),
					rand_sample(), rand_sample());
			if ($urandom_range(0, 2) != 0) begin
				in_valid <= 0;
				repeat ($urandom_range(1, 12)) @(posedge clk);
			end
		end
		drop_valid();
	endtask

	logic signed [15:0] decls[7] = '{0, 18000, -18000, 1234, -32768, 32767, -9000};
	logic signed [15:0] corner[5] = '{16'sh8000, 16'sh7fff, 0, 1, -1};

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		// special cases: zero vectors, axis points, extremes
		foreach (corner[i])
			foreach (corner[j])
				send_sample(corner[i], corner[j], corner[(i + j) % 5],
					corner[j], corner[i]);
		drop_valid();
		drain();
		stall_random = 1;
		foreach (decls[k]) begin
			write_declination(decls[k]);
			send_sample(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
			send_sample(16'd0, 16'd0, 16'd0, -16'sd5, 16'd0);
			send_sample(16'd0, 16'd0, 16'd0, 16'sd7, -16'sd3);
			random_phase(240);
			drain();
		end
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
